### src/sqdm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqdm_pkg
// Shared types and constants of the split queue descriptor manager.
// ----------------------------------------------------------------------------
package sqdm_pkg;

  // Ring geometry (index fields are six bits wide)
  localparam int RING_SIZE = 64;
  localparam int IDX_W     = $clog2(RING_SIZE);
  localparam int CNT_W     = 16;
  localparam int FREE_W    = IDX_W + 1;

  // Field widths
  localparam int MODE_W    = 3;
  localparam int STATUS_W  = 2;
  localparam int ADDR_W    = 64;
  localparam int LEN_W     = 32;
  localparam int FLAGS_W   = 16;

  // Memory word widths
  localparam int DESC_W    = ADDR_W + LEN_W + FLAGS_W;
  localparam int USED_W    = IDX_W + LEN_W;

  // Operation codes
  typedef enum logic [MODE_W-1:0] {
    MODE_ADD      = 3'd0,
    MODE_GET_USED = 3'd1,
    MODE_FREE     = 3'd2,
    MODE_COMPLETE = 3'd3,
    MODE_READ     = 3'd4
  } mode_e;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_NO_FREE   = 2'd1,
    STAT_NO_USED   = 2'd2,
    STAT_OVER_FREE = 2'd3
  } status_e;

  // Controller states
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_e;

  // One input item
  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [ADDR_W-1:0]  buf_addr;
    logic [LEN_W-1:0]   buf_len;
    logic [FLAGS_W-1:0] buf_flags;
    logic [IDX_W-1:0]   desc_index;
    logic [IDX_W-1:0]   done_id;
    logic [LEN_W-1:0]   done_len;
  } item_t;

  // One result item
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [IDX_W-1:0]    index_out;
    logic [LEN_W-1:0]    used_len;
    logic [CNT_W-1:0]    avail_count;
    logic [FREE_W-1:0]   free_left;
    logic [ADDR_W-1:0]   rd_addr;
    logic [LEN_W-1:0]    rd_len;
    logic [FLAGS_W-1:0]  rd_flags;
  } result_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;    // latch item, launch memory reads
    logic commit;  // update state, write memories, load result
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_stall;  // result register full and not being taken
  } dpath_sts_t;

endpackage

### src/sqdm_channels.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqdm channels
// Valid/ready channel interfaces for input items and result items.
// ----------------------------------------------------------------------------
interface sqdm_in_if;
  import sqdm_pkg::*;

  logic               valid;
  logic               ready;
  logic [MODE_W-1:0]  mode;
  logic [ADDR_W-1:0]  buf_addr;
  logic [LEN_W-1:0]   buf_len;
  logic [FLAGS_W-1:0] buf_flags;
  logic [IDX_W-1:0]   desc_index;
  logic [IDX_W-1:0]   done_id;
  logic [LEN_W-1:0]   done_len;

  modport source (
    output valid, mode, buf_addr, buf_len, buf_flags, desc_index, done_id, done_len,
    input  ready
  );
  modport sink (
    input  valid, mode, buf_addr, buf_len, buf_flags, desc_index, done_id, done_len,
    output ready
  );
endinterface

interface sqdm_out_if;
  import sqdm_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [IDX_W-1:0]    index_out;
  logic [LEN_W-1:0]    used_len;
  logic [CNT_W-1:0]    avail_count;
  logic [FREE_W-1:0]   free_left;
  logic [ADDR_W-1:0]   rd_addr;
  logic [LEN_W-1:0]    rd_len;
  logic [FLAGS_W-1:0]  rd_flags;

  modport source (
    output valid, status, index_out, used_len, avail_count, free_left,
           rd_addr, rd_len, rd_flags,
    input  ready
  );
  modport sink (
    input  valid, status, index_out, used_len, avail_count, free_left,
           rd_addr, rd_len, rd_flags,
    output ready
  );
endinterface

### src/sqdm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqdm_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module sqdm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port, holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### src/sqdm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqdm_ctrl
// Two-state sequencer: take an item, then commit it once the result
// register can accept the outcome.
// ----------------------------------------------------------------------------
module sqdm_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  sqdm_pkg::dpath_sts_t sts,
  output sqdm_pkg::ctrl_cmd_t  cmd
);
  import sqdm_pkg::*;

  state_e state_r;
  state_e state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (!sts.out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready   = 1'b0;
    cmd.load   = 1'b0;
    cmd.commit = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_EXEC: begin
        cmd.commit = !sts.out_stall;
      end
      default: ;
    endcase
  end

endmodule

### src/sqdm_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqdm_dpath
// Descriptor table, free-list links, used ring, ring indices and the
// result register.
// ----------------------------------------------------------------------------
module sqdm_dpath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sqdm_pkg::ctrl_cmd_t  cmd,
  output sqdm_pkg::dpath_sts_t sts,
  input  sqdm_pkg::item_t      item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output sqdm_pkg::result_t    result
);
  import sqdm_pkg::*;

  // latched item
  item_t item_r;

  // queue state
  logic [IDX_W-1:0]     free_top_r,   free_top_nxt;
  logic [FREE_W-1:0]    free_total_r, free_total_nxt;
  logic [CNT_W-1:0]     avail_head_r, avail_head_nxt;
  logic [CNT_W-1:0]     used_head_r,  used_head_nxt;
  logic [CNT_W-1:0]     last_seen_r,  last_seen_nxt;
  logic [RING_SIZE-1:0] desc_vld_r,   desc_vld_nxt;
  logic [RING_SIZE-1:0] link_vld_r,   link_vld_nxt;

  // result register
  logic    out_valid_r;
  result_t result_r, result_nxt;

  // memory ports
  logic              link_we;
  logic [IDX_W-1:0]  link_waddr;
  logic [IDX_W-1:0]  link_wdata;
  logic [IDX_W-1:0]  link_rdata;
  logic              desc_we;
  logic [DESC_W-1:0] desc_rdata;
  logic              used_we;
  logic [USED_W-1:0] used_rdata;

  // decoded read data
  logic [IDX_W-1:0]   link_next;
  logic [ADDR_W-1:0]  stored_addr;
  logic [LEN_W-1:0]   stored_len;
  logic [FLAGS_W-1:0] stored_flags;

  // free-list links; an untouched entry still chains to the next index
  sqdm_ram #(.WIDTH(IDX_W), .DEPTH(RING_SIZE)) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .re    (cmd.load),
    .raddr (free_top_r),
    .rdata (link_rdata)
  );

  // descriptor table: address, length, flags
  sqdm_ram #(.WIDTH(DESC_W), .DEPTH(RING_SIZE)) u_desc_ram (
    .clk   (clk),
    .we    (desc_we),
    .waddr (free_top_r),
    .wdata ({item_r.buf_addr, item_r.buf_len, item_r.buf_flags}),
    .re    (cmd.load),
    .raddr (item.desc_index),
    .rdata (desc_rdata)
  );

  // used ring: id and length
  sqdm_ram #(.WIDTH(USED_W), .DEPTH(RING_SIZE)) u_used_ram (
    .clk   (clk),
    .we    (used_we),
    .waddr (used_head_r[IDX_W-1:0]),
    .wdata ({item_r.done_id, item_r.done_len}),
    .re    (cmd.load),
    .raddr (last_seen_r[IDX_W-1:0]),
    .rdata (used_rdata)
  );

  // cleared entries read as zero, unwritten links as the reset chain
  assign link_next = link_vld_r[free_top_r] ? link_rdata : free_top_r + 1'b1;
  always_comb begin
    if (desc_vld_r[item_r.desc_index]) begin
      {stored_addr, stored_len, stored_flags} = desc_rdata;
    end else begin
      stored_addr  = '0;
      stored_len   = '0;
      stored_flags = '0;
    end
  end

  // item latch
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= item;
    end
  end

  // operation decode and state update
  always_comb begin
    free_top_nxt   = free_top_r;
    free_total_nxt = free_total_r;
    avail_head_nxt = avail_head_r;
    used_head_nxt  = used_head_r;
    last_seen_nxt  = last_seen_r;
    desc_vld_nxt   = desc_vld_r;
    link_vld_nxt   = link_vld_r;
    link_we        = 1'b0;
    link_waddr     = free_top_r;
    link_wdata     = '0;
    desc_we        = 1'b0;
    used_we        = 1'b0;
    result_nxt     = '0;
    result_nxt.status = STAT_OK;

    if (cmd.commit) begin
      case (mode_e'(item_r.mode))
        MODE_ADD: begin
          if (free_total_r == '0) begin
            result_nxt.status = STAT_NO_FREE;
          end else begin
            // pop the head of the free list and fill it
            result_nxt.index_out     = free_top_r;
            free_top_nxt             = link_next;
            free_total_nxt           = free_total_r - 1'b1;
            desc_we                  = 1'b1;
            desc_vld_nxt[free_top_r] = 1'b1;
            link_we                  = 1'b1;
            link_vld_nxt[free_top_r] = 1'b1;
            avail_head_nxt           = avail_head_r + 1'b1;
          end
        end
        MODE_GET_USED: begin
          if (last_seen_r == used_head_r) begin
            result_nxt.status = STAT_NO_USED;
          end else begin
            {result_nxt.index_out, result_nxt.used_len} = used_rdata;
            last_seen_nxt = last_seen_r + 1'b1;
          end
        end
        MODE_FREE: begin
          result_nxt.index_out = item_r.desc_index;
          if (free_total_r >= FREE_W'(RING_SIZE)) begin
            result_nxt.status = STAT_OVER_FREE;
          end else begin
            // clear the descriptor and push it onto the free list
            desc_vld_nxt[item_r.desc_index] = 1'b0;
            link_we                         = 1'b1;
            link_waddr                      = item_r.desc_index;
            link_wdata                      = free_top_r;
            link_vld_nxt[item_r.desc_index] = 1'b1;
            free_top_nxt                    = item_r.desc_index;
            free_total_nxt                  = free_total_r + 1'b1;
          end
        end
        MODE_COMPLETE: begin
          used_we       = 1'b1;
          used_head_nxt = used_head_r + 1'b1;
        end
        MODE_READ: begin
          result_nxt.index_out = item_r.desc_index;
          result_nxt.rd_addr   = stored_addr;
          result_nxt.rd_len    = stored_len;
          result_nxt.rd_flags  = stored_flags;
        end
        default: ;
      endcase
    end

    result_nxt.avail_count = avail_head_nxt;
    result_nxt.free_left   = free_total_nxt;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_top_r   <= '0;
      free_total_r <= FREE_W'(RING_SIZE);
      avail_head_r <= '0;
      used_head_r  <= '0;
      last_seen_r  <= '0;
      desc_vld_r   <= '0;
      link_vld_r   <= '0;
    end else begin
      free_top_r   <= free_top_nxt;
      free_total_r <= free_total_nxt;
      avail_head_r <= avail_head_nxt;
      used_head_r  <= used_head_nxt;
      last_seen_r  <= last_seen_nxt;
      desc_vld_r   <= desc_vld_nxt;
      link_vld_r   <= link_vld_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      result_r <= result_nxt;
    end
  end

  assign sts.out_stall = out_valid_r && !out_ready;
  assign out_valid     = out_valid_r;
  assign result        = result_r;

endmodule

### src/split_queue_descriptor_manager_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// split_queue_descriptor_manager_unit
// Driver side of a split virtqueue: linked free list of descriptors,
// descriptor table, used ring and ring indices.
// ----------------------------------------------------------------------------
// Flow: an accepted item starts registered reads of the link, descriptor and
// used memories, then commits to the result register; no new item before that.
// Reset: indices cleared and free count set to the ring size; free list and
// descriptor table take their reset contents at once through per-entry
// valid bits; no clear pass.
// ----------------------------------------------------------------------------
module split_queue_descriptor_manager_unit (
  input  logic              clk,
  input  logic              rst_n,
  sqdm_in_if.sink           in_if,
  sqdm_out_if.source        out_if
);
  import sqdm_pkg::*;

  ctrl_cmd_t  cmd;
  dpath_sts_t sts;
  item_t      item;
  result_t    result;

  // gather the input payload
  assign item.mode       = in_if.mode;
  assign item.buf_addr   = in_if.buf_addr;
  assign item.buf_len    = in_if.buf_len;
  assign item.buf_flags  = in_if.buf_flags;
  assign item.desc_index = in_if.desc_index;
  assign item.done_id    = in_if.done_id;
  assign item.done_len   = in_if.done_len;

  sqdm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sqdm_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .item      (item),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .result    (result)
  );

  // spread the result payload
  assign out_if.status      = result.status;
  assign out_if.index_out   = result.index_out;
  assign out_if.used_len    = result.used_len;
  assign out_if.avail_count = result.avail_count;
  assign out_if.free_left   = result.free_left;
  assign out_if.rd_addr     = result.rd_addr;
  assign out_if.rd_len      = result.rd_len;
  assign out_if.rd_flags    = result.rd_flags;

endmodule

### test/split_queue_descriptor_manager_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// split_queue_descriptor_manager_unit_tb
// Drives add, get-used, free, completion, read and spare-code requests into the
// descriptor manager under random back-pressure on both channels. A local
// copy of the free list, descriptor table and rings predicts every reply,
// and each reply is compared field by field in arrival order.
// ----------------------------------------------------------------------------
module split_queue_descriptor_manager_unit_tb;
  import sqdm_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned RANDOM_ITEMS = 440;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam int unsigned DRAIN_CYCLES = 10;

  // Mode codes the block has no operation for
  localparam logic [MODE_W-1:0] MODE_SPARE_FIRST = 3'd5;
  localparam logic [MODE_W-1:0] MODE_SPARE_LAST  = 3'd7;

  logic clk;
  logic rst_n;

  sqdm_in_if  in_ch ();
  sqdm_out_if out_ch ();

  split_queue_descriptor_manager_unit i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  // Shadow of the queue manager state
  logic [IDX_W-1:0]   link_mem  [RING_SIZE];
  logic [ADDR_W-1:0]  addr_mem  [RING_SIZE];
  logic [LEN_W-1:0]   len_mem   [RING_SIZE];
  logic [FLAGS_W-1:0] flags_mem [RING_SIZE];
  logic [IDX_W-1:0]   used_id_mem  [RING_SIZE];
  logic [LEN_W-1:0]   used_len_mem [RING_SIZE];
  logic [CNT_W-1:0]   avail_ptr;
  logic [CNT_W-1:0]   used_wr_idx;
  logic [CNT_W-1:0]   used_rd_idx;
  logic [IDX_W-1:0]   list_top;
  logic [FREE_W-1:0]  free_cnt;
  bit                 desc_held [RING_SIZE];  // handed out and not yet freed

  result_t     replies_due [$];
  int unsigned mismatches;
  bit          send_eager;
  bit          recv_eager;

  // Clock and reset
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
  end

  // Run limit
  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("split_queue_descriptor_manager_unit test failed");
    $finish;
  end

  // Shadow state after reset: list chained in index order
  task automatic queue_mgr_reset();
    for (int i = 0; i < RING_SIZE; i++) begin
      link_mem[i]     = IDX_W'((i + 1) % RING_SIZE);
      addr_mem[i]     = '0;
      len_mem[i]      = '0;
      flags_mem[i]    = '0;
      used_id_mem[i]  = '0;
      used_len_mem[i] = '0;
      desc_held[i]    = 1'b0;
    end
    avail_ptr   = '0;
    used_wr_idx = '0;
    used_rd_idx = '0;
    list_top    = '0;
    free_cnt    = FREE_W'(RING_SIZE);
  endtask

  // Apply one request to the shadow state and return the reply it gives
  task automatic queue_mgr_step(input item_t req, output result_t rep);
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] slot;
    rep = '0;
    case (req.mode)
      MODE_ADD: begin
        if (free_cnt == 0) begin
          rep.status = STAT_NO_FREE;
        end else begin
          idx            = list_top;
          list_top       = link_mem[idx];
          free_cnt       = free_cnt - 1'b1;
          addr_mem[idx]  = req.buf_addr;
          len_mem[idx]   = req.buf_len;
          flags_mem[idx] = req.buf_flags;
          link_mem[idx]  = '0;
          avail_ptr      = avail_ptr + 1'b1;
          desc_held[idx] = 1'b1;
          rep.index_out  = idx;
        end
      end
      MODE_GET_USED: begin
        if (used_rd_idx == used_wr_idx) begin
          rep.status = STAT_NO_USED;
        end else begin
          slot          = used_rd_idx[IDX_W-1:0];
          rep.index_out = used_id_mem[slot];
          rep.used_len  = used_len_mem[slot];
          used_rd_idx   = used_rd_idx + 1'b1;
        end
      end
      MODE_FREE: begin
        rep.index_out = req.desc_index;
        if (free_cnt >= RING_SIZE) begin
          rep.status = STAT_OVER_FREE;
        end else begin
          // a descriptor already on the list is simply linked again
          idx            = req.desc_index;
          addr_mem[idx]  = '0;
          len_mem[idx]   = '0;
          flags_mem[idx] = '0;
          link_mem[idx]  = list_top;
          list_top       = idx;
          free_cnt       = free_cnt + 1'b1;
          desc_held[idx] = 1'b0;
        end
      end
      MODE_COMPLETE: begin
        // oldest slots are overwritten once the ring is lapped
        slot               = used_wr_idx[IDX_W-1:0];
        used_id_mem[slot]  = req.done_id;
        used_len_mem[slot] = req.done_len;
        used_wr_idx        = used_wr_idx + 1'b1;
      end
      MODE_READ: begin
        rep.index_out = req.desc_index;
        rep.rd_addr   = addr_mem[req.desc_index];
        rep.rd_len    = len_mem[req.desc_index];
        rep.rd_flags  = flags_mem[req.desc_index];
      end
      default: begin
      end
    endcase
    rep.avail_count = avail_ptr;
    rep.free_left   = free_cnt;
  endtask

  // Request with random payload, sometimes all ones or all zeros
  function automatic item_t rand_item(logic [MODE_W-1:0] m);
    item_t it;
    int unsigned pick;
    it.mode       = m;
    it.buf_addr   = {$urandom, $urandom};
    it.buf_len    = $urandom;
    it.buf_flags  = FLAGS_W'($urandom);
    it.desc_index = IDX_W'($urandom);
    it.done_id    = IDX_W'($urandom);
    it.done_len   = $urandom;
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      it.buf_addr  = '1;
      it.buf_len   = '1;
      it.buf_flags = '1;
      it.done_len  = '1;
    end else if (pick == 1) begin
      it.buf_addr  = '0;
      it.buf_len   = '0;
      it.buf_flags = '0;
      it.done_len  = '0;
    end
    return it;
  endfunction

  // A descriptor currently handed out, or any index when none is
  function automatic logic [IDX_W-1:0] pick_held();
    logic [IDX_W-1:0] held_ids [$];
    for (int i = 0; i < RING_SIZE; i++)
      if (desc_held[i]) held_ids.push_back(IDX_W'(i));
    if (held_ids.size() == 0) return IDX_W'($urandom);
    return held_ids[$urandom_range(0, held_ids.size() - 1)];
  endfunction

  // Send one request; the reply is predicted at the transfer
  task automatic send_item(input item_t it);
    int unsigned gap;
    result_t rep;
    gap = send_eager ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.mode       <= it.mode;
    in_ch.buf_addr   <= it.buf_addr;
    in_ch.buf_len    <= it.buf_len;
    in_ch.buf_flags  <= it.buf_flags;
    in_ch.desc_index <= it.desc_index;
    in_ch.done_id    <= it.done_id;
    in_ch.done_len   <= it.done_len;
    in_ch.valid      <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    queue_mgr_step(it, rep);
    replies_due.push_back(rep);
    @(negedge clk);
  endtask

  // Result channel back-pressure
  initial begin
    int unsigned stall;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      stall = recv_eager ? 0 : $urandom_range(0, 9);
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
      @(negedge clk);
    end
  end

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      if (mismatches < MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, name, want, got);
      mismatches++;
    end
  endtask

  // Reply checker
  result_t want_rep;
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (replies_due.size() == 0) begin
        if (mismatches < MAX_REPORTS)
          $display("%0t: reply with no request outstanding", $realtime);
        mismatches++;
      end else begin
        want_rep = replies_due.pop_front();
        check_field("status",      want_rep.status,      out_ch.status);
        check_field("index_out",   want_rep.index_out,   out_ch.index_out);
        check_field("used_len",    want_rep.used_len,    out_ch.used_len);
        check_field("avail_count", want_rep.avail_count, out_ch.avail_count);
        check_field("free_left",   want_rep.free_left,   out_ch.free_left);
        check_field("rd_addr",     want_rep.rd_addr,     out_ch.rd_addr);
        check_field("rd_len",      want_rep.rd_len,      out_ch.rd_len);
        check_field("rd_flags",    want_rep.rd_flags,    out_ch.rd_flags);
      end
    end
  end

  // Field extremes, every mode and the corner cases from reset
  task automatic test_directed();
    item_t it;
    // empty used ring, over-free with every descriptor free, read of a clean entry
    send_item(rand_item(MODE_GET_USED));
    it = rand_item(MODE_FREE);
    it.desc_index = 6'd5;
    send_item(it);
    it = rand_item(MODE_READ);
    it.desc_index = '1;
    send_item(it);
    // adds at both payload extremes
    it = rand_item(MODE_ADD);
    it.buf_addr  = '1;
    it.buf_len   = '1;
    it.buf_flags = '1;
    send_item(it);
    it = rand_item(MODE_ADD);
    it.buf_addr  = '0;
    it.buf_len   = '0;
    it.buf_flags = '0;
    send_item(it);
    send_item(rand_item(MODE_ADD));
    for (int i = 0; i < 3; i++) begin
      it = rand_item(MODE_READ);
      it.desc_index = IDX_W'(i);
      send_item(it);
    end
    // completions at the id and length extremes, popped back
    it = rand_item(MODE_COMPLETE);
    it.done_id  = '0;
    it.done_len = '1;
    send_item(it);
    it = rand_item(MODE_COMPLETE);
    it.done_id  = '1;
    it.done_len = '0;
    send_item(it);
    repeat (3) send_item(rand_item(MODE_GET_USED));
    // free clears the entry; freeing it again relinks it unnoticed
    it = rand_item(MODE_FREE);
    it.desc_index = 6'd1;
    send_item(it);
    it = rand_item(MODE_READ);
    it.desc_index = 6'd1;
    send_item(it);
    it = rand_item(MODE_FREE);
    it.desc_index = 6'd1;
    send_item(it);
    repeat (2) send_item(rand_item(MODE_ADD));
    // codes with no operation
    for (int m = MODE_SPARE_FIRST; m <= MODE_SPARE_LAST; m++)
      send_item(rand_item(MODE_W'(m)));
  endtask

  // Drain the free list, add once more, return every descriptor, then free once more
  task automatic test_list_exhaustion();
    item_t it;
    int unsigned order [RING_SIZE];
    while (free_cnt != 0) send_item(rand_item(MODE_ADD));
    send_item(rand_item(MODE_ADD));
    for (int i = 0; i < RING_SIZE; i++) order[i] = i;
    order.shuffle();
    for (int i = 0; i < RING_SIZE; i++) begin
      it = rand_item(MODE_FREE);
      it.desc_index = IDX_W'(order[i]);
      send_item(it);
    end
    it = rand_item(MODE_FREE);
    send_item(it);
  endtask

  // Lap the used ring so the oldest completions are overwritten
  task automatic test_used_ring_lap();
    repeat (RING_SIZE + 6) send_item(rand_item(MODE_COMPLETE));
    while (used_rd_idx != used_wr_idx) send_item(rand_item(MODE_GET_USED));
    send_item(rand_item(MODE_GET_USED));
  endtask

  // Mode mix leaning towards allocation or towards release
  function automatic logic [MODE_W-1:0] pick_mode(bit fill);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < (fill ? 30 : 10)) return MODE_ADD;
    if (r < 40) return MODE_FREE;
    if (r < 60) return MODE_COMPLETE;
    if (r < 80) return MODE_GET_USED;
    if (r < 95) return MODE_READ;
    return MODE_W'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST));
  endfunction

  task automatic test_random_traffic();
    item_t it;
    int unsigned done_cnt;
    logic [MODE_W-1:0] m;
    done_cnt = 0;
    while (done_cnt < RANDOM_ITEMS) begin
      if ($urandom_range(0, 39) == 0) begin
        send_eager = ($urandom_range(0, 3) == 0);
        recv_eager = ($urandom_range(0, 3) == 0);
      end
      m  = pick_mode(((done_cnt / 60) % 2) == 0);
      it = rand_item(m);
      // mostly act on descriptors that are really handed out
      if ($urandom_range(0, 9) < 8) begin
        if (m == MODE_FREE || m == MODE_READ) it.desc_index = pick_held();
        if (m == MODE_COMPLETE) it.done_id = pick_held();
      end
      send_item(it);
      if (m <= MODE_READ) done_cnt++;
    end
  endtask

  // Main sequence
  initial begin
    in_ch.valid      = 1'b0;
    in_ch.mode       = MODE_ADD;
    in_ch.buf_addr   = '0;
    in_ch.buf_len    = '0;
    in_ch.buf_flags  = '0;
    in_ch.desc_index = '0;
    in_ch.done_id    = '0;
    in_ch.done_len   = '0;
    mismatches = 0;
    send_eager = 1'b0;
    recv_eager = 1'b0;
    queue_mgr_reset();
    wait (rst_n === 1'b1);
    @(negedge clk);

    test_directed();
    test_list_exhaustion();
    test_used_ring_lap();
    test_random_traffic();

    in_ch.valid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && replies_due.size() == 0) begin
      $display("split_queue_descriptor_manager_unit test passed");
    end else begin
      $display("split_queue_descriptor_manager_unit test failed");
    end
    $finish;
  end

endmodule
